@@ rtl/complementable_integer_set_table_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef COMPLEMENTABLE_INTEGER_SET_TABLE_MACROS_SVH
`define COMPLEMENTABLE_INTEGER_SET_TABLE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CIST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CIST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/cist_pkg.sv @@
`default_nettype none

package cist_pkg;

   // Fixed port widths.
   localparam int VALUE_PORT_BITS = 32;
   localparam int COUNT_BITS      = 5;

   // Command codes.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;
   localparam logic [1:0] CMD_FLIP   = 2'd3;

   // Controller to datapath.
   typedef struct packed {
      logic load;        // capture the new item, clear per-item flags
      logic flip;        // toggle the complement flag
      logic scan;        // step the table scan
      logic rd_last;     // read the last listed entry
      logic push;        // append the operand
      logic move;        // copy last entry into the matched slot
      logic mark_full;   // flag a dropped append
      logic rsp_load;    // load the result register
   } cist_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       scan_done;
      logic       found;
      logic       is_full;
      logic       flag;
      logic [1:0] op;
   } cist_status_type;

endpackage

`default_nettype wire

@@ rtl/cist_ram.sv @@
`default_nettype none

module cist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                    clock,
   input  wire                    wr_en,
   input  wire [ADDR_W-1:0]       wr_addr,
   input  wire [WIDTH-1:0]        wr_data,
   input  wire [ADDR_W-1:0]       rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cist_datapath.sv @@
`default_nettype none

module cist_datapath #(
   parameter int MAX_ENTRIES = 16,
   parameter int VALUE_BITS  = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  cist_pkg::cist_cmd_type              cmd,
   output cist_pkg::cist_status_type           status,
   input  wire [1:0]                           req_cmd,
   input  wire [cist_pkg::VALUE_PORT_BITS-1:0] req_value,
   output logic                                rsp_is_member,
   output logic                                rsp_status,
   output logic                                rsp_complemented,
   output logic [cist_pkg::COUNT_BITS-1:0]     rsp_entry_count
);

   localparam int CMP_BITS = (VALUE_BITS < cist_pkg::VALUE_PORT_BITS) ?
                             VALUE_BITS : cist_pkg::VALUE_PORT_BITS;
   localparam int ADDR_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);

   logic [1:0]          op_ff;
   logic [CMP_BITS-1:0] val_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                flag_ff, flag_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]   rd_idx_ff;
   logic [ADDR_W-1:0]   slot_ff;
   logic                found_ff;
   logic                full_ff;
   logic                member_ff, status_ff, compl_ff;
   logic [cist_pkg::COUNT_BITS-1:0] count_out_ff;

   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [CMP_BITS-1:0] rd_data, wr_data;
   logic                wr_en;
   logic                hit, issue;

   cist_ram #(
      .WIDTH (CMP_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit   = rd_vld_ff && (rd_data == val_ff);
   assign issue = cmd.scan && (idx_ff < count_ff) && !hit;

   assign rd_addr = cmd.rd_last ? ADDR_W'(count_ff - CNT_W'(1)) : idx_ff[ADDR_W-1:0];
   assign wr_en   = cmd.push || cmd.move;
   assign wr_addr = cmd.move ? slot_ff : count_ff[ADDR_W-1:0];
   assign wr_data = cmd.move ? rd_data : val_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.move) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign flag_in   = flag_ff ^ cmd.flip;
   assign idx_in    = cmd.load ? '0 : (issue ? idx_ff + CNT_W'(1) : idx_ff);
   assign rd_vld_in = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         flag_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         flag_ff   <= flag_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      rd_idx_ff <= idx_ff[ADDR_W-1:0];
      if (cmd.load) begin
         op_ff    <= req_cmd;
         val_ff   <= req_value[CMP_BITS-1:0];
         found_ff <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         if (cmd.scan && hit) begin
            found_ff <= 1'b1;
            slot_ff  <= rd_idx_ff;
         end
         if (cmd.push) begin
            found_ff <= 1'b1;
         end
         if (cmd.move) begin
            found_ff <= 1'b0;
         end
         if (cmd.mark_full) begin
            full_ff <= 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         member_ff    <= (op_ff != cist_pkg::CMD_FLIP) && (found_ff ^ flag_ff);
         status_ff    <= full_ff;
         compl_ff     <= flag_ff;
         count_out_ff <= cist_pkg::COUNT_BITS'(count_ff);
      end
   end

   assign status.scan_done = hit || (!rd_vld_ff && (idx_ff >= count_ff));
   assign status.found     = found_ff || hit;
   assign status.is_full   = (count_ff == CNT_W'(MAX_ENTRIES));
   assign status.flag      = flag_ff;
   assign status.op        = op_ff;

   assign rsp_is_member    = member_ff;
   assign rsp_status       = status_ff;
   assign rsp_complemented = compl_ff;
   assign rsp_entry_count  = count_out_ff;

endmodule

`default_nettype wire

@@ rtl/cist_controller.sv @@
`default_nettype none

module cist_controller (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [1:0]                   req_cmd,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output cist_pkg::cist_cmd_type      cmd,
   input  cist_pkg::cist_status_type   status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_MOVE = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       want_add, want_rem;

   assign want_add = ((status.op == cist_pkg::CMD_INSERT) && !status.flag) ||
                     ((status.op == cist_pkg::CMD_DELETE) && status.flag);
   assign want_rem = ((status.op == cist_pkg::CMD_INSERT) && status.flag) ||
                     ((status.op == cist_pkg::CMD_DELETE) && !status.flag);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_cmd == cist_pkg::CMD_FLIP) begin
                  cmd.flip = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_RESP;
               if (want_rem && status.found) begin
                  cmd.rd_last = 1'b1;
                  state_in    = S_MOVE;
               end else if (want_add && !status.found) begin
                  if (status.is_full) begin
                     cmd.mark_full = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
            end
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/complementable_integer_set_table.sv @@
// Items are handled one at a time: a new request is stalled until the result of the
//   last one is loaded; the scan reads one entry per cycle through the single read
//   port of the table.
// Reset (synchronous, active high): empty list, flag clear, no result; table kept.
`default_nettype none

module complementable_integer_set_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int VALUE_BITS  = 32
) (
   input  wire                                        clock,
   input  wire                                        reset,
   // request channel
   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire [1:0]                                  req_cmd,
   input  wire signed [cist_pkg::VALUE_PORT_BITS-1:0] req_value,
   // response channel
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic                                       rsp_is_member,
   output logic                                       rsp_status,
   output logic                                       rsp_complemented,
   output logic [cist_pkg::COUNT_BITS-1:0]            rsp_entry_count
);

   // The controller sequences each item: capture, scan the listed entries for
   // the operand, then append, swap-remove or leave the list alone, and finally
   // load the result register. Flip skips the scan.
   cist_pkg::cist_cmd_type    cmd;
   cist_pkg::cist_status_type status;

   cist_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the entry table, count, complement flag, scan pointer
   // and the result register. Only the low VALUE_BITS bits of the operand, at most
   // VALUE_PORT_BITS, are kept and compared.
   cist_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_is_member    (rsp_is_member),
      .rsp_status       (rsp_status),
      .rsp_complemented (rsp_complemented),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire

@@ rtl/cist_checker.sv @@
`default_nettype none
`include "complementable_integer_set_table_macros.svh"

module cist_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire                                rsp_status,
   input wire [cist_pkg::COUNT_BITS-1:0]     rsp_entry_count
);

   `CIST_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")
   `CIST_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")
   `CIST_ASSERT(a_count_bound, rsp_valid |-> (rsp_entry_count <= MAX_ENTRIES), "count too big")
   `CIST_ASSERT(a_full_count, rsp_valid && rsp_status |-> (rsp_entry_count == cist_pkg::COUNT_BITS'(MAX_ENTRIES)), "drop without full table")

endmodule

bind complementable_integer_set_table cist_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire
